>>> rtl/plps_pkg.sv
package plps_pkg;

  // field widths
  localparam int COORD_BITS = 24;
  localparam int DIST_W     = 48;
  localparam int PEAK_W     = COORD_BITS - 1;
  localparam int COUNT_W    = 32;

  // datapath widths: coordinate difference, root, radicand, partial remainder
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int ROOT_W  = DIFF_W;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int CNT_W   = $clog2(ROOT_W);

  // square phase: three axes, then a final step with no axis to fold in the last product
  localparam int SQ_LAST = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_COMMIT
  } plps_state_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z,
    AXIS_NONE
  } plps_axis_t;

  typedef struct packed {
    logic       load;
    logic       sq_en;
    plps_axis_t axis;
    logic       root_init;
    logic       root_step;
    logic       commit;
  } plps_cmd_t;

endpackage

>>> rtl/plps_in_if.sv
interface plps_in_if;
  import plps_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  coord_t speed_sample;
  logic   new_track;

  modport source (
    output valid, pos_x, pos_y, pos_z, speed_sample, new_track,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, speed_sample, new_track,
    output ready
  );

endinterface

>>> rtl/plps_out_if.sv
interface plps_out_if;
  import plps_pkg::*;

  logic                valid;
  logic                ready;
  logic [DIST_W-1:0]   total_distance;
  logic [PEAK_W-1:0]   peak_speed;
  logic [COUNT_W-1:0]  points_seen;
  logic                distance_saturated;

  modport source (
    output valid, total_distance, peak_speed, points_seen, distance_saturated,
    input  ready
  );

  modport sink (
    input  valid, total_distance, peak_speed, points_seen, distance_saturated,
    output ready
  );

endinterface

>>> rtl/plps_ctrl.sv
module plps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output plps_pkg::plps_cmd_t cmd
);
  import plps_pkg::*;

  plps_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.axis      = AXIS_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.sq_en = 1'b1;
        case (cnt_r[1:0])
          2'd0:    cmd.axis = AXIS_X;
          2'd1:    cmd.axis = AXIS_Y;
          2'd2:    cmd.axis = AXIS_Z;
          default: cmd.axis = AXIS_NONE;
        endcase
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT_INIT;
        end
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/plps_dp.sv
module plps_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  plps_pkg::plps_cmd_t            cmd,
  input  plps_pkg::coord_t               pos_x,
  input  plps_pkg::coord_t               pos_y,
  input  plps_pkg::coord_t               pos_z,
  input  plps_pkg::coord_t               speed_sample,
  input  logic                           new_track,
  output logic [plps_pkg::DIST_W-1:0]    total_distance,
  output logic [plps_pkg::PEAK_W-1:0]    peak_speed,
  output logic [plps_pkg::COUNT_W-1:0]   points_seen,
  output logic                           distance_saturated
);
  import plps_pkg::*;

  localparam logic [DIST_W-1:0]  DIST_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // latched item
  coord_t x_r, y_r, z_r, s_r;

  // track state
  coord_t              last_x_r, last_y_r, last_z_r;
  logic                have_last_r;
  logic [DIST_W-1:0]   dist_r, dist_nxt;
  logic [PEAK_W-1:0]   peak_r, peak_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                sat_r, sat_nxt;

  // square and root working registers
  logic [RAD_W-1:0]    prod_r;
  logic [RAD_W-1:0]    sumsq_r;
  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;

  // result register
  logic [DIST_W-1:0]   total_distance_r;
  logic [PEAK_W-1:0]   peak_speed_r;
  logic [COUNT_W-1:0]  points_seen_r;
  logic                distance_saturated_r;

  logic signed [DIFF_W-1:0] cur_c, last_c, diff;
  logic [DIFF_W-1:0]        mag;
  logic [RAD_W-1:0]         prod_nxt;
  logic [REM_W-1:0]         rem_sh, trial;
  logic [DIST_W:0]          sum_ext;

  // one axis difference and magnitude per cycle
  always_comb begin
    case (cmd.axis)
      AXIS_X: begin
        cur_c  = DIFF_W'(x_r);
        last_c = DIFF_W'(last_x_r);
      end
      AXIS_Y: begin
        cur_c  = DIFF_W'(y_r);
        last_c = DIFF_W'(last_y_r);
      end
      AXIS_Z: begin
        cur_c  = DIFF_W'(z_r);
        last_c = DIFF_W'(last_z_r);
      end
      default: begin
        cur_c  = '0;
        last_c = '0;
      end
    endcase
    diff     = cur_c - last_c;
    mag      = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    prod_nxt = RAD_W'(mag) * RAD_W'(mag);
  end

  // two radicand bits per root bit
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};

  // commit values
  always_comb begin
    sum_ext   = {1'b0, dist_r} + (DIST_W + 1)'(root_r);
    dist_nxt  = dist_r;
    sat_nxt   = sat_r;
    peak_nxt  = peak_r;
    count_nxt = count_r;
    if (have_last_r) begin
      if (sum_ext >= {1'b0, DIST_MAX}) begin
        dist_nxt = DIST_MAX;
        sat_nxt  = 1'b1;
      end else begin
        dist_nxt = sum_ext[DIST_W-1:0];
      end
    end
    if (!s_r[COORD_BITS-1] && (s_r[PEAK_W-1:0] > peak_r)) begin
      peak_nxt = s_r[PEAK_W-1:0];
    end
    if (count_r != COUNT_MAX) begin
      count_nxt = count_r + 1'b1;
    end
  end

  // track state, cleared by reset or a new track
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      have_last_r <= 1'b0;
      dist_r      <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
    end else if (cmd.load && new_track) begin
      have_last_r <= 1'b0;
      dist_r      <= '0;
      peak_r      <= '0;
      count_r     <= '0;
      sat_r       <= 1'b0;
    end else if (cmd.commit) begin
      last_x_r    <= x_r;
      last_y_r    <= y_r;
      last_z_r    <= z_r;
      have_last_r <= 1'b1;
      dist_r      <= dist_nxt;
      peak_r      <= peak_nxt;
      count_r     <= count_nxt;
      sat_r       <= sat_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= pos_x;
      y_r     <= pos_y;
      z_r     <= pos_z;
      s_r     <= speed_sample;
      prod_r  <= '0;
      sumsq_r <= '0;
    end
    if (cmd.sq_en) begin
      prod_r  <= prod_nxt;
      sumsq_r <= sumsq_r + prod_r;
    end
    if (cmd.root_init) begin
      rad_r  <= sumsq_r;
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.root_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.commit) begin
      total_distance_r     <= dist_nxt;
      peak_speed_r         <= peak_nxt;
      points_seen_r        <= count_nxt;
      distance_saturated_r <= sat_nxt;
    end
  end

  assign total_distance     = total_distance_r;
  assign peak_speed         = peak_speed_r;
  assign points_seen        = points_seen_r;
  assign distance_saturated = distance_saturated_r;

endmodule

>>> rtl/path_length_and_peak_speed.sv
// a point is taken only in idle, then runs load, square/accumulate on the shared multiplier
//   (one axis per step, then a final step to fold in the last product), setup, the 25-step
//   bit-serial square root (the longest phase) and commit; the next point waits for that commit
// out valid is registered and set by the commit, and holds until out ready
// a finished result waits in its own register, so the next point can be taken meanwhile
// reset (synchronous, active low) clears the previous point, totals, peak, count and flag
module path_length_and_peak_speed (
  input  logic       clk,
  input  logic       rst_n,
  plps_in_if.sink    in_ch,
  plps_out_if.source out_ch
);
  import plps_pkg::*;

  // command bundle from the sequencer to the datapath
  plps_cmd_t cmd;

  // sequencer: load, square each axis, root one bit a cycle, then commit
  plps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // datapath: segment length, saturating total, peak speed, point count
  plps_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .pos_x              (in_ch.pos_x),
    .pos_y              (in_ch.pos_y),
    .pos_z              (in_ch.pos_z),
    .speed_sample       (in_ch.speed_sample),
    .new_track          (in_ch.new_track),
    .total_distance     (out_ch.total_distance),
    .peak_speed         (out_ch.peak_speed),
    .points_seen        (out_ch.points_seen),
    .distance_saturated (out_ch.distance_saturated)
  );

endmodule

>>> tb/path_length_and_peak_speed_test.sv
`timescale 1ns / 100ps

module path_length_and_peak_speed_test;
  import plps_pkg::*;

  localparam coord_t C_MAX = 24'sh7FFFFF;
  localparam coord_t C_MIN = 24'sh800000;
  localparam int RANDOM_POINTS = 400;
  localparam int HOLD_CYCLES = 150;   // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 40;   // quiet time after the last expected result
  localparam int IDLE_LIMIT = 2000;   // cycles without any transfer before giving up

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t speed;
    logic   fresh;
  } point_t;

  typedef struct {
    logic [DIST_W-1:0]  total_distance;
    logic [PEAK_W-1:0]  peak_speed;
    logic [COUNT_W-1:0] points_seen;
    logic               distance_saturated;
  } totals_t;

  // running totals of the path, one expected totals record per accepted point
  class path_totals_board;
    localparam logic [DIST_W-1:0] DIST_FULL = '1;

    coord_t             prev_x, prev_y, prev_z;
    bit                 have_prev;
    logic [DIST_W-1:0]  dist_sum;
    logic [PEAK_W-1:0]  peak;
    logic [COUNT_W-1:0] count;
    bit                 sat;
    totals_t            pending_totals[$];
    int unsigned        errors;

    function new();
      prev_x = '0;
      prev_y = '0;
      prev_z = '0;
      have_prev = 0;
      dist_sum = '0;
      peak = '0;
      count = '0;
      sat = 0;
      errors = 0;
    endfunction

    function void note_point(point_t p);
      longint signed   dx, dy, dz;
      longint unsigned radicand, rem, trial, root;
      totals_t         t;
      if (p.fresh) begin
        have_prev = 0;
        dist_sum = '0;
        peak = '0;
        count = '0;
        sat = 0;
      end
      if (have_prev) begin
        dx = longint'(p.x) - longint'(prev_x);
        dy = longint'(p.y) - longint'(prev_y);
        dz = longint'(p.z) - longint'(prev_z);
        radicand = longint'(dx * dx) + longint'(dy * dy) + longint'(dz * dz);
        // floor square root, two radicand bits per step, 26 steps cover 52 bits
        root = 0;
        rem = 0;
        for (int i = 25; i >= 0; i--) begin
          rem = (rem << 2) | ((radicand >> (2 * i)) & 64'd3);
          trial = (root << 2) | 64'd1;
          if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 64'd1;
          end else begin
            root = root << 1;
          end
        end
        if (root >= DIST_FULL - dist_sum) begin
          dist_sum = DIST_FULL;
          sat = 1;
        end else begin
          dist_sum = dist_sum + root[DIST_W-1:0];
        end
      end
      if (p.speed > 0 && longint'(p.speed) > longint'(peak))
        peak = p.speed[PEAK_W-1:0];
      if (count != '1)
        count = count + 1'b1;
      prev_x = p.x;
      prev_y = p.y;
      prev_z = p.z;
      have_prev = 1;
      t.total_distance = dist_sum;
      t.peak_speed = peak;
      t.points_seen = count;
      t.distance_saturated = sat;
      pending_totals = {pending_totals, t};
    endfunction

    function void check_totals(totals_t got);
      totals_t want;
      if (pending_totals.size() == 0) begin
        $error("result transfer with no point outstanding: distance %0d count %0d",
               got.total_distance, got.points_seen);
        errors++;
        return;
      end
      want = pending_totals.pop_front();
      if (got.total_distance !== want.total_distance) begin
        $error("total_distance: expected %0d, actual %0d",
               want.total_distance, got.total_distance);
        errors++;
      end
      if (got.peak_speed !== want.peak_speed) begin
        $error("peak_speed: expected %0d, actual %0d", want.peak_speed, got.peak_speed);
        errors++;
      end
      if (got.points_seen !== want.points_seen) begin
        $error("points_seen: expected %0d, actual %0d", want.points_seen, got.points_seen);
        errors++;
      end
      if (got.distance_saturated !== want.distance_saturated) begin
        $error("distance_saturated: expected %0d, actual %0d",
               want.distance_saturated, got.distance_saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  plps_in_if  in_ch ();
  plps_out_if out_ch ();

  path_length_and_peak_speed dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  path_totals_board totals = new();

  bit idling_on = 1;      // random bursts of idling on both channels
  bit hold_request = 0;   // asks the receiver for one long hold-off
  int idle_cycles = 0;    // cycles since the last transfer on either channel

  // free-running clock, 10 ns period
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // drive every input to a known value from time zero
  initial begin
    rst_n = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.pos_z <= '0;
    in_ch.speed_sample <= '0;
    in_ch.new_track <= 1'b0;
  end

  // transfers are sampled at the rising edge, results checked before points noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        totals.check_totals(totals_t'{out_ch.total_distance, out_ch.peak_speed,
                                      out_ch.points_seen, out_ch.distance_saturated});
      if (in_ch.valid && in_ch.ready)
        totals.note_point(point_t'{in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                                   in_ch.speed_sample, in_ch.new_track});
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // watchdog: nothing moving for too long means the block has hung
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic point_t mk_point(coord_t x, coord_t y, coord_t z, coord_t speed,
                                      logic fresh);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.speed = speed;
    p.fresh = fresh;
    return p;
  endfunction

  // offer one point and hold it until the transfer, then maybe leave a gap
  task automatic send_point(point_t p);
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= p.x;
    in_ch.pos_y <= p.y;
    in_ch.pos_z <= p.z;
    in_ch.speed_sample <= p.speed;
    in_ch.new_track <= p.fresh;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // small random step along one axis, wrapping is harmless
  function automatic coord_t nudge(coord_t c);
    int delta;
    delta = $urandom_range(0, 1 << $urandom_range(0, 14));
    if ($urandom_range(0, 1))
      delta = -delta;
    return c + coord_t'(delta);
  endfunction

  initial begin
    point_t cur;
    int     pick;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: first point after reset, full-swing segments on every axis
    send_point(mk_point(C_MAX, C_MAX, C_MAX, C_MAX, 1'b0));
    send_point(mk_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));
    send_point(mk_point(C_MAX, C_MIN, C_MAX, 24'sd0, 1'b0));
    // zero-length segment, small speed below the peak
    send_point(mk_point(C_MAX, C_MIN, C_MAX, 24'sd1, 1'b0));
    // new track with a negative speed leaves the peak at zero
    send_point(mk_point(24'sd0, 24'sd0, 24'sd0, -24'sd1, 1'b1));
    send_point(mk_point(24'sd1, 24'sd0, 24'sd0, 24'sd0, 1'b0));
    send_point(mk_point(24'sd2, 24'sd1, 24'sd0, 24'sd1, 1'b0));
    send_point(mk_point(24'sd3, 24'sd2, 24'sd1, 24'sd2, 1'b0));
    // 3-4-5 triangle gives an exact root
    send_point(mk_point(24'sd0, 24'sd0, 24'sd0, 24'sd5, 1'b1));
    send_point(mk_point(24'sd768, 24'sd1024, 24'sd0, 24'sd4, 1'b0));
    // new track with the top speed, then single-axis full swings
    send_point(mk_point(C_MIN, 24'sd0, 24'sd0, C_MAX, 1'b1));
    send_point(mk_point(C_MAX, 24'sd0, 24'sd0, C_MIN, 1'b0));
    send_point(mk_point(C_MAX, C_MIN, 24'sd0, 24'sd100, 1'b0));
    send_point(mk_point(C_MAX, C_MIN, C_MIN, 24'sd0, 1'b0));
    send_point(mk_point(C_MAX, C_MIN, C_MAX, -24'sd5, 1'b0));
    // back-to-back new tracks
    send_point(mk_point(24'sd7, -24'sd7, 24'sd7, 24'sd3, 1'b1));
    send_point(mk_point(-24'sd7, 24'sd7, -24'sd7, 24'sd0, 1'b1));
    send_point(mk_point(C_MIN, C_MIN, C_MIN, C_MIN, 1'b0));

    // random tracks: mostly small steps, some jumps and fresh starts
    cur = mk_point(24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0);
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      idling_on = (n < RANDOM_POINTS - 60) && ((n / 50) % 3 != 2);
      if (n == 150)
        hold_request = 1;
      pick = $urandom_range(0, 99);
      cur.fresh = (pick < 5);
      if (pick < 5 || pick >= 85) begin
        cur.x = coord_t'($urandom());
        cur.y = coord_t'($urandom());
        cur.z = coord_t'($urandom());
      end else begin
        cur.x = nudge(cur.x);
        cur.y = nudge(cur.y);
        cur.z = nudge(cur.z);
      end
      case ($urandom_range(0, 3))
        0: cur.speed = coord_t'($urandom());
        1: cur.speed = coord_t'($urandom_range(0, 8192));
        2: cur.speed = -coord_t'($urandom_range(0, 8192));
        default: cur.speed = C_MAX - coord_t'($urandom_range(0, 1 << 20));
      endcase
      send_point(cur);
    end
    in_ch.valid <= 1'b0;

    // drain: every expected result in, then a quiet stretch of DRAIN_CYCLES
    while (totals.pending_totals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (totals.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
